### hw/rtl/lidar_gps_timestamp_rebuild_unit_assert.svh
// Assertion macros for the checker file of the time stamp rebuild unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LIDAR_GPS_TIMESTAMP_REBUILD_UNIT_ASSERT_SVH
`define LIDAR_GPS_TIMESTAMP_REBUILD_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define LGTR_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lgtr assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define LGTR_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgtr assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LGTR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgtr assertion failed");

`endif

### hw/rtl/lgtr_pkg.sv
package lgtr_pkg;

    // Input operation codes.
    localparam logic OP_TIME   = 1'b0;
    localparam logic OP_PACKET = 1'b1;

    // Only time messages that open with this header are taken.
    localparam logic [31:0] TIME_HEADER = 32'hA5FF005A;

    localparam logic [19:0] US_MAX = 20'd999999;
    localparam int NS_PER_US          = 1000;
    localparam int MINUTES_PER_HOUR   = 60;
    localparam int MINUTE_WRAP_GAP    = 59;
    localparam int HOURS_PER_DAY      = 24;
    localparam int MONTHS_PER_YEAR    = 12;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int SECONDS_PER_HOUR   = 3600;
    localparam int SECONDS_PER_DAY    = 86400;
    localparam int DAYS_PER_YEAR      = 365;
    // Years between 1600 and 2000; the day count works on years since 1600.
    localparam int YEAR_BIAS          = 400;
    // Days from 1600-03-01 back to 1970-01-01, plus one for the day-of-month base.
    localparam int DAYS_OFFSET        = 135081;

    // One packet as classified by the front end.
    typedef struct packed {
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [19:0] microsecond;
        logic        advance;
        logic        stamp_valid;
        logic        time_known;
    } pkt_t;

    // Gregorian leap test on 2000 + y for y below 256.
    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'b00) && (y != 8'd100) && (y != 8'd200);
    endfunction

    // Length of month m (1 to 12) in year 2000 + y.
    function automatic logic [4:0] month_days(input logic [7:0] y, input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                       len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    // Days from March 1 to the first of the month, for the raw month code.
    // Codes 0 and 13 to 15 fold into December of the year before and
    // January to March of the year after.
    function automatic logic [8:0] march_doy(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd0:  d = 9'd275;
            4'd1:  d = 9'd306;
            4'd2:  d = 9'd337;
            4'd3:  d = 9'd0;
            4'd4:  d = 9'd31;
            4'd5:  d = 9'd61;
            4'd6:  d = 9'd92;
            4'd7:  d = 9'd122;
            4'd8:  d = 9'd153;
            4'd9:  d = 9'd184;
            4'd10: d = 9'd214;
            4'd11: d = 9'd245;
            4'd12: d = 9'd275;
            4'd13: d = 9'd306;
            4'd14: d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // March-based year counted from 1600, for year 2000 + y and raw month m.
    function automatic logic [9:0] shifted_year(input logic [8:0] y, input logic [3:0] m);
        logic [9:0] base;
        logic [9:0] a;
        base = {1'b0, y} + 10'(YEAR_BIAS);
        unique case (m)
            4'd0, 4'd1, 4'd2: a = base - 10'd1;
            4'd15:            a = base + 10'd1;
            default:          a = base;
        endcase
        return a;
    endfunction

    // Quotient by 100 of a value below 1000, by threshold count.
    function automatic logic [3:0] div100(input logic [9:0] a);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (a >= 10'(k * 100)) begin
                q = q + 4'd1;
            end
        end
        return q;
    endfunction

    // Quotient by 400 of a ten-bit value.
    function automatic logic [1:0] div400(input logic [9:0] a);
        return {1'b0, (a >= 10'd400)} + {1'b0, (a >= 10'd800)};
    endfunction

endpackage

### hw/rtl/lidar_gps_timestamp_rebuild_unit.sv
// Rebuilds UTC time stamps for lidar data packets. Time messages (op 0) whose
// header word is 0xA5FF005A load the stored calendar time (years since 2000,
// month, day, hour, minute); other headers are dropped silently. Each data
// packet (op 1) gives one result: seconds since 1970 and the packet's
// microseconds times 1000 (saturated at 999999 microseconds), tagged with the
// sync enable bit and with whether any time message has arrived. A minute-lag
// tracker decides whether the stored minute trails the packet by one; if so
// the stamp's minute is advanced with a full Gregorian carry, while the stored
// time stays as it was. The front end takes one transaction per cycle while
// the queue is not full and handles time messages on the spot. Packets go
// through a short queue to the back end, one at a time: dequeue, calendar
// carry, day count, and the seconds-per-day multiply into the result register.
// A result waiting to be popped holds the back end but does not stop the
// front end until the queue fills. The sync enable register should be
// written only while no packet is in flight.
module lidar_gps_timestamp_rebuild_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        op,
    input  logic [31:0] header_word,
    input  logic [7:0]  msg_year,
    input  logic [3:0]  msg_month,
    input  logic [4:0]  msg_day,
    input  logic [4:0]  msg_hour,
    input  logic [5:0]  msg_minute,
    input  logic [5:0]  pkt_second,
    input  logic [19:0] pkt_microsecond,
    input  logic        cfg_write,
    input  logic        cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [33:0] epoch_seconds,
    output logic [29:0] nanoseconds,
    output logic        stamp_valid,
    output logic        time_known
);

    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    lgtr_pkg::pkt_t q_in;
    lgtr_pkg::pkt_t q_out;

    // Front end: header check, stored calendar, minute-lag tracking.
    lgtr_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .op              (op),
        .header_word     (header_word),
        .msg_year        (msg_year),
        .msg_month       (msg_month),
        .msg_day         (msg_day),
        .msg_hour        (msg_hour),
        .msg_minute      (msg_minute),
        .pkt_second      (pkt_second),
        .pkt_microsecond (pkt_microsecond),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .q_push          (q_push),
        .q_data          (q_in)
    );

    // Packet queue; when it fills, the whole input side stalls.
    lgtr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // Back end: carry, epoch arithmetic and the result register.
    lgtr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .epoch_seconds (epoch_seconds),
        .nanoseconds   (nanoseconds),
        .stamp_valid   (stamp_valid),
        .time_known    (time_known)
    );

endmodule

### hw/rtl/lgtr_front.sv
module lgtr_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic                 op,
    input  logic [31:0]          header_word,
    input  logic [7:0]           msg_year,
    input  logic [3:0]           msg_month,
    input  logic [4:0]           msg_day,
    input  logic [4:0]           msg_hour,
    input  logic [5:0]           msg_minute,
    input  logic [5:0]           pkt_second,
    input  logic [19:0]          pkt_microsecond,
    input  logic                 cfg_write,
    input  logic                 cfg_data,
    output logic                 q_push,
    output lgtr_pkg::pkt_t       q_data
);

    logic [7:0] stored_year_reg,   stored_year_next;
    logic [3:0] stored_month_reg,  stored_month_next;
    logic [4:0] stored_day_reg,    stored_day_next;
    logic [4:0] stored_hour_reg,   stored_hour_next;
    logic [5:0] stored_minute_reg, stored_minute_next;
    logic       have_time_reg,     have_time_next;
    logic [5:0] current_reg,       current_next;
    logic [5:0] previous_reg,      previous_next;
    logic [5:0] latched_reg,       latched_next;
    logic       armed_reg,         armed_next;
    logic       sync_enable_reg,   sync_enable_next;

    logic        accept;
    logic        step_seen;
    logic        advance;
    logic [19:0] us_sat;

    assign accept = push && !full;
    assign us_sat = (pkt_microsecond > lgtr_pkg::US_MAX) ? lgtr_pkg::US_MAX : pkt_microsecond;

    // The stored minute is one past the latched one, with wrap at the hour.
    assign step_seen = ({1'b0, stored_minute_reg} == {1'b0, latched_reg} + 7'd1)
                    || ({1'b0, latched_reg} ==
                        {1'b0, stored_minute_reg} + 7'(lgtr_pkg::MINUTE_WRAP_GAP));

    always_comb
    begin
        stored_year_next   = stored_year_reg;
        stored_month_next  = stored_month_reg;
        stored_day_next    = stored_day_reg;
        stored_hour_next   = stored_hour_reg;
        stored_minute_next = stored_minute_reg;
        have_time_next     = have_time_reg;
        current_next       = current_reg;
        previous_next      = previous_reg;
        latched_next       = latched_reg;
        armed_next         = armed_reg;
        sync_enable_next   = cfg_write ? cfg_data : sync_enable_reg;
        advance            = 1'b0;
        q_push             = 1'b0;

        if (accept) begin
            if (op == lgtr_pkg::OP_TIME) begin
                if (header_word == lgtr_pkg::TIME_HEADER) begin
                    stored_year_next   = msg_year;
                    stored_month_next  = msg_month;
                    stored_day_next    = msg_day;
                    stored_hour_next   = msg_hour;
                    stored_minute_next = msg_minute;
                    have_time_next     = 1'b1;
                end
            end else begin
                q_push        = 1'b1;
                previous_next = current_reg;
                current_next  = stored_minute_reg;
                if (step_seen && (pkt_second > 6'd1)) begin
                    armed_next = 1'b1;
                end
                if ((pkt_second == 6'd0) && (current_reg == stored_minute_reg)) begin
                    if (armed_next) begin
                        latched_next = stored_minute_reg;
                        armed_next   = 1'b0;
                    end
                    advance = (stored_minute_reg == latched_next);
                end
            end
        end
    end

    always_comb
    begin
        q_data.year        = stored_year_reg;
        q_data.month       = stored_month_reg;
        q_data.day         = stored_day_reg;
        q_data.hour        = stored_hour_reg;
        q_data.minute      = stored_minute_reg;
        q_data.second      = pkt_second;
        q_data.microsecond = us_sat;
        q_data.advance     = advance;
        q_data.stamp_valid = sync_enable_reg;
        q_data.time_known  = have_time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stored_year_reg   <= '0;
            stored_month_reg  <= '0;
            stored_day_reg    <= '0;
            stored_hour_reg   <= '0;
            stored_minute_reg <= '0;
            have_time_reg     <= 1'b0;
            current_reg       <= '0;
            previous_reg      <= '0;
            latched_reg       <= '0;
            armed_reg         <= 1'b1;
            sync_enable_reg   <= 1'b0;
        end else begin
            stored_year_reg   <= stored_year_next;
            stored_month_reg  <= stored_month_next;
            stored_day_reg    <= stored_day_next;
            stored_hour_reg   <= stored_hour_next;
            stored_minute_reg <= stored_minute_next;
            have_time_reg     <= have_time_next;
            current_reg       <= current_next;
            previous_reg      <= previous_next;
            latched_reg       <= latched_next;
            armed_reg         <= armed_next;
            sync_enable_reg   <= sync_enable_next;
        end
    end

endmodule

### hw/rtl/lgtr_queue.sv
module lgtr_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lgtr_pkg::pkt_t push_data,
    output logic           full,
    input  logic           pop,
    output lgtr_pkg::pkt_t pop_data,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lgtr_pkg::pkt_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/lgtr_back.sv
module lgtr_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  lgtr_pkg::pkt_t q_data,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [33:0]    epoch_seconds,
    output logic [29:0]    nanoseconds,
    output logic           stamp_valid,
    output logic           time_known
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CARRY,
        S_DAYS,
        S_SECS
    } state_t;

    state_t         state_reg;
    lgtr_pkg::pkt_t work_reg;

    logic [8:0]  year_reg;
    logic [3:0]  month_reg;
    logic [5:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [16:0] days_reg;
    logic [16:0] tod_reg;
    logic [29:0] ns_reg;

    logic        out_valid_reg;
    logic [33:0] epoch_reg;
    logic [29:0] nanoseconds_reg;
    logic        stamp_valid_reg;
    logic        time_known_reg;

    // Calendar carry on the work item.
    logic [8:0]  year_next;
    logic [3:0]  month_next;
    logic [5:0]  day_next;
    logic [4:0]  hour_next;
    logic [5:0]  minute_next;
    logic [6:0]  minute_inc;
    logic [5:0]  hour_inc;
    logic [5:0]  day_inc;
    logic [3:0]  month_inc;

    // Day count and seconds.
    logic [9:0]  shifted;
    logic [18:0] days_sum;
    logic [16:0] tod_sum;
    logic [29:0] ns_prod;
    logic [33:0] secs_sum;
    logic        out_free;
    logic        load_out;

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || pop;
    assign load_out = (state_reg == S_SECS) && out_free;

    assign minute_inc = {1'b0, work_reg.minute} + 7'd1;
    assign hour_inc   = {1'b0, work_reg.hour} + 6'd1;
    assign day_inc    = {1'b0, work_reg.day} + 6'd1;
    assign month_inc  = work_reg.month + 4'd1;

    always_comb
    begin
        year_next   = {1'b0, work_reg.year};
        month_next  = work_reg.month;
        day_next    = {1'b0, work_reg.day};
        hour_next   = work_reg.hour;
        minute_next = work_reg.minute;
        if (work_reg.advance) begin
            if (minute_inc >= 7'(lgtr_pkg::MINUTES_PER_HOUR)) begin
                minute_next = '0;
                if (hour_inc >= 6'(lgtr_pkg::HOURS_PER_DAY)) begin
                    hour_next = '0;
                    day_next  = day_inc;
                    // A month code outside the calendar has no length, so the
                    // day only counts up.
                    if ((work_reg.month >= 4'd1)
                        && (work_reg.month <= 4'(lgtr_pkg::MONTHS_PER_YEAR))
                        && (day_inc > {1'b0,
                            lgtr_pkg::month_days(work_reg.year, work_reg.month)})) begin
                        day_next = 6'd1;
                        if (month_inc > 4'(lgtr_pkg::MONTHS_PER_YEAR)) begin
                            month_next = 4'd1;
                            year_next  = {1'b0, work_reg.year} + 9'd1;
                        end else begin
                            month_next = month_inc;
                        end
                    end
                end else begin
                    hour_next = hour_inc[4:0];
                end
            end else begin
                minute_next = minute_inc[5:0];
            end
        end
    end

    assign shifted  = lgtr_pkg::shifted_year(year_reg, month_reg);
    assign days_sum = 19'(shifted) * 19'(lgtr_pkg::DAYS_PER_YEAR)
                    + 19'(shifted[9:2])
                    + 19'(lgtr_pkg::div400(shifted))
                    + 19'(lgtr_pkg::march_doy(month_reg))
                    + 19'(day_reg)
                    - 19'(lgtr_pkg::div100(shifted))
                    - 19'(lgtr_pkg::DAYS_OFFSET);
    assign tod_sum  = 17'(hour_reg) * 17'(lgtr_pkg::SECONDS_PER_HOUR)
                    + 17'(minute_reg) * 17'(lgtr_pkg::SECONDS_PER_MINUTE)
                    + 17'(work_reg.second);
    assign ns_prod  = 30'(work_reg.microsecond) * 30'(lgtr_pkg::NS_PER_US);
    assign secs_sum = {17'b0, days_reg} * 34'(lgtr_pkg::SECONDS_PER_DAY) + {17'b0, tod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= S_IDLE;
            work_reg        <= '0;
            year_reg        <= '0;
            month_reg       <= '0;
            day_reg         <= '0;
            hour_reg        <= '0;
            minute_reg      <= '0;
            days_reg        <= '0;
            tod_reg         <= '0;
            ns_reg          <= '0;
            out_valid_reg   <= 1'b0;
            epoch_reg       <= '0;
            nanoseconds_reg <= '0;
            stamp_valid_reg <= 1'b0;
            time_known_reg  <= 1'b0;
        end else begin
            // A new result replaces the one being taken in the same cycle.
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && pop) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty) begin
                        work_reg  <= q_data;
                        state_reg <= S_CARRY;
                    end
                end
                S_CARRY:
                begin
                    year_reg   <= year_next;
                    month_reg  <= month_next;
                    day_reg    <= day_next;
                    hour_reg   <= hour_next;
                    minute_reg <= minute_next;
                    state_reg  <= S_DAYS;
                end
                S_DAYS:
                begin
                    days_reg  <= days_sum[16:0];
                    tod_reg   <= tod_sum;
                    ns_reg    <= ns_prod;
                    state_reg <= S_SECS;
                end
                S_SECS:
                begin
                    if (out_free) begin
                        epoch_reg       <= secs_sum;
                        nanoseconds_reg <= ns_reg;
                        stamp_valid_reg <= work_reg.stamp_valid;
                        time_known_reg  <= work_reg.time_known;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign empty         = !out_valid_reg;
    assign epoch_seconds = epoch_reg;
    assign nanoseconds   = nanoseconds_reg;
    assign stamp_valid   = stamp_valid_reg;
    assign time_known    = time_known_reg;

endmodule

### hw/rtl/lgtr_checker.sv
`include "lidar_gps_timestamp_rebuild_unit_assert.svh"

module lgtr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [33:0] epoch_seconds,
    input logic [29:0] nanoseconds,
    input logic        stamp_valid,
    input logic        time_known
);

    logic seen_known_reg;

    // Set once a result that reported a known time has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seen_known_reg <= 1'b0;
        end else if (!empty && pop && time_known) begin
            seen_known_reg <= 1'b1;
        end
    end

    // A waiting result stays put until it is taken.
    `LGTR_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(epoch_seconds) && $stable(nanoseconds) && $stable(stamp_valid) && $stable(time_known))

    // Nanoseconds have their low three bits clear, as a multiple of 1000 does, and never pass the saturated value.
    `LGTR_ASSERT_IMPLIES(a_ns_aligned, !empty, nanoseconds[2:0] == 3'b000)
    `LGTR_ASSERT_IMPLIES(a_ns_bounded, !empty, nanoseconds <= 30'd999999000)

    // Once the calendar time is known it stays known for later results.
    `LGTR_ASSERT_IMPLIES(a_known_sticky, !empty && seen_known_reg, time_known)

endmodule

bind lidar_gps_timestamp_rebuild_unit lgtr_checker u_lgtr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .epoch_seconds (epoch_seconds),
    .nanoseconds   (nanoseconds),
    .stamp_valid   (stamp_valid),
    .time_known    (time_known)
);

### sim/lidar_gps_timestamp_rebuild_unit_tb.sv
module lidar_gps_timestamp_rebuild_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One rebuilt time stamp as the block presents it on its result ports.
    typedef struct {
        logic [33:0] secs;
        logic [29:0] ns;
        logic        valid;
        logic        known;
    } stamp_t;

    // Calendar time used to build well-formed message streams.
    typedef struct {
        int y;
        int mo;
        int d;
        int h;
        int mi;
    } cal_t;

    // The scoreboard keeps its own copy of the stored calendar, the minute-lag
    // tracker and the sync enable bit. Each accepted input transaction is run
    // through the same rules as the block, and every data packet leaves one
    // expected stamp in a queue that the result side consumes in order.
    class stamp_scoreboard;
        logic [7:0] st_year;
        logic [3:0] st_month;
        logic [4:0] st_day;
        logic [4:0] st_hour;
        logic [5:0] st_minute;
        logic       time_seen;
        int         cur_min;
        int         prev_min;
        int         latch_min;
        bit         armed;
        bit         sync_en;
        stamp_t     expected_stamps[$];
        int         mismatches;
        int         results_seen;

        function new();
            st_year    = '0;
            st_month   = '0;
            st_day     = '0;
            st_hour    = '0;
            st_minute  = '0;
            time_seen  = 1'b0;
            cur_min    = 0;
            prev_min   = 0;
            latch_min  = 0;
            armed      = 1'b1;
            sync_en    = 1'b0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        static function bit is_leap_year(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int month_length(int y, int m);
            int len[12];
            len = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            if (m == 2 && is_leap_year(y))
            begin
                return 29;
            end
            return len[(m - 1) % 12];
        endfunction

        // Days from 1970-01-01 to the first day of month m (1 to 12) of year y.
        static function longint days_since_epoch(longint y, longint m);
            longint yy;
            longint era;
            longint yoe;
            longint mp;
            longint doy;
            longint doe;
            yy  = (m <= 2) ? y - 1 : y;
            era = yy / 400;
            yoe = yy - era * 400;
            mp  = (m + 9) % 12;
            doy = (153 * mp + 2) / 5;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe - 719468;
        endfunction

        function void set_sync(logic value);
            sync_en = value;
        endfunction

        function int outstanding();
            return expected_stamps.size();
        endfunction

        function void note_input(logic op_i, logic [31:0] hdr, logic [7:0] yr,
                                 logic [3:0] mo, logic [4:0] dy, logic [4:0] hr,
                                 logic [5:0] mi, logic [5:0] sec_i, logic [19:0] us_i);
            int     minute;
            int     hour;
            int     day;
            int     month;
            int     year;
            int     sec;
            longint us;
            longint m0;
            longint yfull;
            longint days;
            longint total;
            stamp_t s;
            if (op_i == lgtr_pkg::OP_TIME)
            begin
                // Any header other than the time header is dropped.
                if (hdr == lgtr_pkg::TIME_HEADER)
                begin
                    st_year   = yr;
                    st_month  = mo;
                    st_day    = dy;
                    st_hour   = hr;
                    st_minute = mi;
                    time_seen = 1'b1;
                end
                return;
            end

            sec = int'(sec_i);
            us  = longint'(us_i);
            if (us > longint'(lgtr_pkg::US_MAX))
            begin
                us = longint'(lgtr_pkg::US_MAX);
            end

            minute = int'(st_minute);
            hour   = int'(st_hour);
            day    = int'(st_day);
            month  = int'(st_month);
            year   = int'(st_year) + 2000;

            prev_min = cur_min;
            cur_min  = minute;

            if ((cur_min - latch_min == 1 || latch_min - cur_min == 59) && sec > 1)
            begin
                armed = 1'b1;
            end

            if (sec == 0 && prev_min == cur_min)
            begin
                if (armed)
                begin
                    latch_min = cur_min;
                    armed     = 1'b0;
                end
                // The stored minute lags the packet: advance this stamp only.
                if (minute == latch_min)
                begin
                    minute = minute + 1;
                    if (minute >= 60)
                    begin
                        minute = 0;
                        hour   = hour + 1;
                        if (hour >= 24)
                        begin
                            hour = 0;
                            day  = day + 1;
                            if (month >= 1 && month <= 12 && day > month_length(year, month))
                            begin
                                day   = 1;
                                month = month + 1;
                                if (month > 12)
                                begin
                                    month = 1;
                                    year  = year + 1;
                                end
                            end
                        end
                    end
                end
            end

            // Month codes 0 and 13 to 15 fold into the neighboring years.
            m0    = longint'(month) - 1;
            yfull = longint'(year);
            if (m0 < 0)
            begin
                m0    = m0 + 12;
                yfull = yfull - 1;
            end
            else if (m0 >= 12)
            begin
                m0    = m0 - 12;
                yfull = yfull + 1;
            end
            days  = days_since_epoch(yfull, m0 + 1) + longint'(day) - 1;
            total = days * 86400 + longint'(hour) * 3600 + longint'(minute) * 60
                    + longint'(sec);

            s.secs  = total[33:0];
            s.ns    = 30'(us * 1000);
            s.valid = sync_en;
            s.known = time_seen;
            expected_stamps.push_back(s);
        endfunction

        task report(string what, longint got, longint want);
            if (mismatches < 50)
            begin
                $display("mismatch at result %0d: %s got %0d, expected %0d",
                         results_seen, what, got, want);
            end
            mismatches++;
        endtask

        task check_result(logic [33:0] secs, logic [29:0] ns, logic valid, logic known);
            stamp_t want;
            if (expected_stamps.size() == 0)
            begin
                report("unexpected result, epoch_seconds", longint'(secs), -1);
            end
            else
            begin
                want = expected_stamps.pop_front();
                if (secs !== want.secs)
                begin
                    report("epoch_seconds", longint'(secs), longint'(want.secs));
                end
                if (ns !== want.ns)
                begin
                    report("nanoseconds", longint'(ns), longint'(want.ns));
                end
                if (valid !== want.valid)
                begin
                    report("stamp_valid", longint'(valid), longint'(want.valid));
                end
                if (known !== want.known)
                begin
                    report("time_known", longint'(known), longint'(want.known));
                end
            end
            results_seen++;
        endtask
    endclass

    // Every input starts at a known value before the first clock edge.
    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        push            = 1'b0;
    logic        full;
    logic        op              = lgtr_pkg::OP_TIME;
    logic [31:0] header_word     = '0;
    logic [7:0]  msg_year        = '0;
    logic [3:0]  msg_month       = '0;
    logic [4:0]  msg_day         = '0;
    logic [4:0]  msg_hour        = '0;
    logic [5:0]  msg_minute      = '0;
    logic [5:0]  pkt_second      = '0;
    logic [19:0] pkt_microsecond = '0;
    logic        cfg_write       = 1'b0;
    logic        cfg_data        = 1'b0;
    logic        empty;
    logic        pop             = 1'b0;
    logic [33:0] epoch_seconds;
    logic [29:0] nanoseconds;
    logic        stamp_valid;
    logic        time_known;

    stamp_scoreboard sb;

    // Sender pacing: bursts of random length separated by random gaps.
    int burst_left = 0;
    bit gaps_on    = 1'b1;
    int items_sent = 0;
    // Set by the stimulus once; the receiver clears it after its long hold-off.
    bit hold_req   = 1'b0;

    lidar_gps_timestamp_rebuild_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .op              (op),
        .header_word     (header_word),
        .msg_year        (msg_year),
        .msg_month       (msg_month),
        .msg_day         (msg_day),
        .msg_hour        (msg_hour),
        .msg_minute      (msg_minute),
        .pkt_second      (pkt_second),
        .pkt_microsecond (pkt_microsecond),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .empty           (empty),
        .pop             (pop),
        .epoch_seconds   (epoch_seconds),
        .nanoseconds     (nanoseconds),
        .stamp_valid     (stamp_valid),
        .time_known      (time_known)
    );

    always #1 clk = ~clk;

    // The monitor samples at the rising edge, before the block's registers
    // update, so it sees exactly the values that the edge acts on. Register
    // writes, accepted input transactions and accepted results are all taken
    // from the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                sb.set_sync(cfg_data);
            end
            if (push && !full)
            begin
                sb.note_input(op, header_word, msg_year, msg_month, msg_day, msg_hour,
                              msg_minute, pkt_second, pkt_microsecond);
            end
            if (pop && !empty)
            begin
                sb.check_result(epoch_seconds, nanoseconds, stamp_valid, time_known);
            end
        end
    end

    // The receiver picks a new pop rate after each span of random length. When
    // asked, it holds pop low for a long stretch so that the block's queue fills
    // and full rises while the sender keeps offering transactions.
    initial
    begin
        int pct;
        int span;
        wait (rst_n);
        forever
        begin
            case ($urandom_range(0, 3))
                0:       pct = 100;
                1:       pct = 70;
                2:       pct = 30;
                default: pct = 5;
            endcase
            span = $urandom_range(30, 200);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    pop <= 1'b0;
                    repeat (400) @(posedge clk);
                    hold_req = 1'b0;
                end
                else
                begin
                    pop <= ($urandom_range(0, 99) < pct);
                end
            end
        end
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic cal_t next_minute(cal_t c);
        cal_t n;
        n = c;
        n.mi++;
        if (n.mi > 59)
        begin
            n.mi = 0;
            n.h++;
            if (n.h > 23)
            begin
                n.h = 0;
                n.d++;
                if (n.d > stamp_scoreboard::month_length(2000 + n.y, n.mo))
                begin
                    n.d = 1;
                    n.mo++;
                    if (n.mo > 12)
                    begin
                        n.mo = 1;
                        n.y  = (n.y + 1) % 256;
                    end
                end
            end
        end
        return n;
    endfunction

    // Dates are biased toward century years, the last year, February, December
    // and the last minute of a month, where the carry does the most work.
    function automatic cal_t pick_date();
        cal_t c;
        case ($urandom_range(0, 5))
            0:       c.y = 0;
            1:       c.y = 100;
            2:       c.y = 200;
            3:       c.y = 255;
            default: c.y = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 3))
            0:       c.mo = 2;
            1:       c.mo = 12;
            default: c.mo = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 3))
            0:       c.d = stamp_scoreboard::month_length(2000 + c.y, c.mo);
            1:       c.d = 28;
            default: c.d = $urandom_range(1, 28);
        endcase
        c.h  = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
        c.mi = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
        return c;
    endfunction

    function automatic logic [19:0] rand_us();
        if ($urandom_range(0, 7) == 0)
        begin
            return 20'($urandom_range(999990, 20'hFFFFF));
        end
        return 20'($urandom_range(0, 999999));
    endfunction

    // Offers one input transaction and returns at the edge that accepts it.
    // The caller is always at a rising edge on entry and on return.
    task automatic offer(logic op_i, logic [31:0] hdr, logic [7:0] yr, logic [3:0] mo,
                         logic [4:0] dy, logic [4:0] hr, logic [5:0] mi,
                         logic [5:0] sec_i, logic [19:0] us_i);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push            <= 1'b1;
        op              <= op_i;
        header_word     <= hdr;
        msg_year        <= yr;
        msg_month       <= mo;
        msg_day         <= dy;
        msg_hour        <= hr;
        msg_minute      <= mi;
        pkt_second      <= sec_i;
        pkt_microsecond <= us_i;
        do
        begin
            @(posedge clk);
        end
        while (full);
        if (op_i == lgtr_pkg::OP_PACKET || hdr == lgtr_pkg::TIME_HEADER)
        begin
            items_sent++;
        end
    endtask

    // Fields that the operation does not use still carry random values.
    task automatic send_time(logic [31:0] hdr, cal_t c);
        offer(lgtr_pkg::OP_TIME, hdr, 8'(c.y), 4'(c.mo), 5'(c.d), 5'(c.h), 6'(c.mi),
              6'($urandom_range(0, 63)), 20'($urandom()));
    endtask

    task automatic send_packet(int sec, logic [19:0] us);
        offer(lgtr_pkg::OP_PACKET, $urandom(), 8'($urandom()), 4'($urandom()),
              5'($urandom()), 5'($urandom()), 6'($urandom()), 6'(sec), us);
    endtask

    task automatic send_seconds_run();
        int sec;
        int n;
        sec = 0;
        n   = $urandom_range(1, 4);
        repeat (n)
        begin
            sec = sec + $urandom_range(1, 15);
            if (sec > 59)
            begin
                sec = 59;
            end
            send_packet(sec, rand_us());
        end
    endtask

    // A well-formed stream: a time message, packets through the minute, and
    // then a few more minutes in which the new time message usually arrives
    // after the first packets of the minute, as the lag tracker expects.
    task automatic run_flow();
        cal_t c;
        int   minutes;
        c       = pick_date();
        minutes = $urandom_range(2, 6);
        send_time(lgtr_pkg::TIME_HEADER, c);
        send_seconds_run();
        repeat (minutes)
        begin
            c = next_minute(c);
            if ($urandom_range(0, 3) != 0)
            begin
                repeat ($urandom_range(1, 3)) send_packet(0, rand_us());
                if ($urandom_range(0, 1))
                begin
                    send_packet(1, rand_us());
                end
                send_time(lgtr_pkg::TIME_HEADER, c);
            end
            else
            begin
                send_time(lgtr_pkg::TIME_HEADER, c);
                send_packet(0, rand_us());
            end
            send_seconds_run();
        end
    endtask

    // Unstructured transactions over the full width of every field, with
    // headers that are right, random, or one bit away from right.
    task automatic send_noise();
        logic [31:0] hdr;
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 3))
                0:       hdr = $urandom();
                1:       hdr = lgtr_pkg::TIME_HEADER ^ (32'd1 << $urandom_range(0, 31));
                default: hdr = lgtr_pkg::TIME_HEADER;
            endcase
            offer(1'($urandom()), hdr, 8'($urandom()), 4'($urandom()), 5'($urandom()),
                  5'($urandom()), 6'($urandom()), 6'($urandom()), 20'($urandom()));
        end
    endtask

    task automatic run_random(int target, bit with_hold);
        int mid;
        mid = items_sent + (target - items_sent) / 2;
        while (items_sent < target)
        begin
            gaps_on = ($urandom_range(0, 4) != 0);
            if (with_hold && items_sent >= mid)
            begin
                hold_req  = 1'b1;
                with_hold = 1'b0;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                send_noise();
            end
            else
            begin
                run_flow();
            end
        end
    endtask

    // Stops offering and waits until every expected result has been popped,
    // then lets the block settle before anything else happens.
    task automatic drain();
        push <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_sync(logic value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_sync(1'b0);
        @(posedge clk);

        // Directed part. A packet before any time message sees the zeroed
        // calendar, where month zero reads as December of the year before.
        send_packet(0, 20'd0);
        // Saturated microseconds and a second beyond its range.
        send_packet(63, 20'hFFFFF);
        // A time message with the wrong header must change nothing.
        send_time(32'h5A00FFA5, '{7, 7, 7, 7, 7});
        // Arm the latch, then lag at the last minute of the last year so the
        // advanced minute carries all the way into the year.
        send_time(lgtr_pkg::TIME_HEADER, '{50, 6, 15, 10, 1});
        send_packet(30, 20'd123456);
        send_time(lgtr_pkg::TIME_HEADER, '{255, 12, 31, 23, 59});
        send_packet(0, 20'd999999);
        send_packet(0, 20'd1000000);
        // Century year that is not a leap year: February 28 rolls to March.
        send_time(lgtr_pkg::TIME_HEADER, '{100, 6, 1, 0, 0});
        send_packet(30, 20'd1);
        send_time(lgtr_pkg::TIME_HEADER, '{100, 2, 28, 23, 59});
        send_packet(0, 20'd2);
        send_packet(0, 20'd3);
        // Year 2000 is a leap year: February 28 rolls to February 29.
        send_time(lgtr_pkg::TIME_HEADER, '{0, 6, 1, 0, 0});
        send_packet(30, 20'd4);
        send_time(lgtr_pkg::TIME_HEADER, '{0, 2, 28, 23, 59});
        send_packet(0, 20'd5);
        send_packet(0, 20'd6);
        // Every calendar field beyond its range, taken at face value.
        send_time(lgtr_pkg::TIME_HEADER, '{255, 0, 0, 31, 63});
        send_packet(63, 20'd999999);
        // A day carry with a month code outside 1 to 12 only bumps the day.
        send_time(lgtr_pkg::TIME_HEADER, '{7, 15, 31, 0, 0});
        send_packet(30, 20'd7);
        send_time(lgtr_pkg::TIME_HEADER, '{7, 15, 31, 23, 59});
        send_packet(0, 20'd8);
        send_packet(0, 20'd9);
        drain();

        // Random phases, each with its own sync enable setting. The first one
        // also carries the long receiver hold-off.
        write_sync(1'b1);
        run_random(items_sent + 380, 1'b1);
        drain();

        write_sync(1'b0);
        run_random(items_sent + 380, 1'b0);
        drain();

        write_sync(1'b1);
        run_random(items_sent + 380, 1'b0);
        drain();

        repeat (20) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            sb.report("results still expected at the end", 0, sb.outstanding());
        end
        if (sb.mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
